@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/bch_pkg.sv @@
//------------------------------------------------------------------------------
// bch_pkg
// Types, GF(64) arithmetic and constant tables for the BCH(63) decoder.
//------------------------------------------------------------------------------
package bch_pkg;

    localparam int NUM_POS    = 63;
    localparam int MAX_SYN    = 12;
    localparam int NSYN_SMALL = 6;
    localparam int T_SMALL    = 3;
    localparam int T_LARGE    = 6;

    typedef logic [5:0] gf_t;
    typedef logic [63:0][5:0] gf_tab_t;
    typedef gf_t [MAX_SYN-1:0] poly_t;

    typedef enum logic [1:0] {
        STAT_CLEAN = 2'd0,
        STAT_FIXED = 2'd1,
        STAT_FAIL  = 2'd2
    } status_t;

    // one decoded word handed from the front end to the search unit
    typedef struct packed {
        logic [63:0] word;
        poly_t       coef;
        logic [3:0]  deg;
        logic        search;
        status_t     status;
    } entry_t;

    typedef enum logic [2:0] {
        F_IDLE, F_SYN, F_SCAN, F_BM_D, F_BM_F, F_BM_U, F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE, B_RUN, B_DONE
    } back_state_t;

    // multiply mod x^6 + x + 1
    function automatic gf_t gf_mul(gf_t a, gf_t b);
        logic [10:0] r;
        r = '0;
        for (int i = 0; i < 6; i++)
            if (b[i])
                r = r ^ (11'(a) << i);
        for (int i = 10; i >= 6; i--)
            if (r[i])
                r = r ^ (11'h43 << (i - 6));
        return r[5:0];
    endfunction

    function automatic gf_tab_t build_pow();
        gf_tab_t tab;
        gf_t     p;
        p = 6'd1;
        for (int e = 0; e < 64; e++)
        begin
            tab[e] = p;
            p = gf_mul(p, 6'd2);
        end
        return tab;
    endfunction

    function automatic gf_tab_t build_inv();
        gf_tab_t tab;
        tab = '0;
        for (int a = 1; a < 64; a++)
            for (int v = 1; v < 64; v++)
                if (gf_mul(6'(a), 6'(v)) == 6'd1)
                    tab[a] = 6'(v);
        return tab;
    endfunction

    localparam gf_tab_t ALPHA_POW = build_pow();
    localparam gf_tab_t GF_INV    = build_inv();

endpackage

@@ rtl/bch63_decoder_top.sv @@
//------------------------------------------------------------------------------
// bch63_decoder_top: BCH(63,45)/BCH(63,30) decoder, syndromes + BM + Chien.
// Clean words and words whose locator degree rules them out skip the search.
// The Chien search overlaps the front end's work on the next word. Reset
// clears all control state, mode = 0.
//------------------------------------------------------------------------------
module bch63_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: mode register, 0 = t=3, 1 = t=6
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input word channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] codeword,
    // result word channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] corrected_word,
    output logic [1:0]  decode_status,
    output logic [2:0]  errors_fixed
);

    // Mode register; sampled by the front end when a word is accepted, so a
    // word in flight keeps its own mode.
    logic code_mode_reg, code_mode_next;

    // queue handshake between front end and search unit
    logic            q_push, q_full, q_pop, q_empty;
    bch_pkg::entry_t q_in_entry, q_out_entry;

    assign code_mode_next = cfg_wr_en ? cfg_wr_data : code_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_mode_reg <= 1'b0;
        else
            code_mode_reg <= code_mode_next;
    end

    // Front end: bit-serial syndrome pass, a zero check, then Berlekamp-Massey
    // iterations in discrepancy, factor and update steps. Clean words and words
    // whose locator degree rules them out skip the search.
    bch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .codeword  (codeword),
        .code_mode (code_mode_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in_entry)
    );

    // two-entry queue lets the front end start the next word while the
    // search unit is busy or the output is stalled
    bch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (q_out_entry),
        .empty      (q_empty)
    );

    // Back end: Chien search, one position per cycle, root count check,
    // bit flips, and the registered output word.
    bch_chien u_chien (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_entry        (q_out_entry),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .corrected_word (corrected_word),
        .decode_status  (decode_status),
        .errors_fixed   (errors_fixed)
    );

endmodule

@@ rtl/bch_queue.sv @@
//------------------------------------------------------------------------------
// bch_queue
// Two-entry queue between the syndrome/locator front end and the search unit.
//------------------------------------------------------------------------------
module bch_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bch_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output bch_pkg::entry_t pop_entry,
    output logic            empty
);

    bch_pkg::entry_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ rtl/bch_front.sv @@
//------------------------------------------------------------------------------
// bch_front
// Accepts a word, computes syndromes bit-serially, runs Berlekamp-Massey
// and classifies the word for the search unit.
//------------------------------------------------------------------------------
module bch_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [63:0]     codeword,
    input  logic            code_mode,
    input  logic            q_full,
    output logic            q_push,
    output bch_pkg::entry_t q_entry
);

    bch_pkg::front_state_t state_reg, state_next;

    logic [63:0]    word_reg;
    logic [63:0]    sh_reg;
    logic [5:0]     cnt_reg;
    logic           mode_reg;
    logic           clean_reg;
    bch_pkg::poly_t syn_reg, hist_reg, c_reg, bs_reg;
    logic [3:0]     len_reg;
    bch_pkg::gf_t   bprev_reg, d_reg, f_reg;

    bch_pkg::gf_t   d_comb;
    logic           syn_any;
    logic           bm_last;
    logic [3:0]     nsyn_last;
    logic [3:0]     t_max;
    logic [11:0]    coef_mask;

    assign nsyn_last = mode_reg ? 4'(bch_pkg::MAX_SYN - 1) : 4'(bch_pkg::NSYN_SMALL - 1);
    assign t_max     = mode_reg ? 4'(bch_pkg::T_LARGE) : 4'(bch_pkg::T_SMALL);
    assign bm_last   = (cnt_reg[3:0] == nsyn_last);

    always_comb
    begin
        for (int i = 0; i < bch_pkg::MAX_SYN; i++)
            coef_mask[i] = (i < bch_pkg::NSYN_SMALL) || mode_reg;
    end

    always_comb
    begin
        syn_any = 1'b0;
        for (int j = 0; j < bch_pkg::MAX_SYN; j++)
            if (coef_mask[j] && syn_reg[j] != '0)
                syn_any = 1'b1;
    end

    // discrepancy: syn_reg[0] is S_n, hist_reg[i-1] is S_(n-i)
    always_comb
    begin
        d_comb = syn_reg[0];
        for (int i = 1; i < bch_pkg::MAX_SYN; i++)
            if (4'(i) <= len_reg)
                d_comb = d_comb ^ bch_pkg::gf_mul(c_reg[i], hist_reg[i-1]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bch_pkg::F_IDLE: if (in_valid) state_next = bch_pkg::F_SYN;
            bch_pkg::F_SYN:  if (cnt_reg == 6'(bch_pkg::NUM_POS - 1))
                                 state_next = bch_pkg::F_SCAN;
            bch_pkg::F_SCAN: state_next = syn_any ? bch_pkg::F_BM_D : bch_pkg::F_PUSH;
            bch_pkg::F_BM_D: state_next = bch_pkg::F_BM_F;
            bch_pkg::F_BM_F: state_next = bch_pkg::F_BM_U;
            bch_pkg::F_BM_U: state_next = bm_last ? bch_pkg::F_PUSH : bch_pkg::F_BM_D;
            bch_pkg::F_PUSH: if (!q_full) state_next = bch_pkg::F_IDLE;
            default:         state_next = bch_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != bch_pkg::F_IDLE);
        q_push   = (state_reg == bch_pkg::F_PUSH);
        q_entry.word   = word_reg;
        q_entry.coef   = c_reg;
        q_entry.deg    = len_reg;
        q_entry.search = 1'b0;
        q_entry.status = bch_pkg::STAT_CLEAN;
        if (!clean_reg)
        begin
            if (len_reg == 4'd0 || len_reg > t_max)
                q_entry.status = bch_pkg::STAT_FAIL;
            else
            begin
                q_entry.search = 1'b1;
                q_entry.status = bch_pkg::STAT_FIXED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bch_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            bch_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    word_reg <= codeword;
                    sh_reg   <= codeword;
                    mode_reg <= code_mode;
                    syn_reg  <= '0;
                    cnt_reg  <= 6'd0;
                end
            end
            bch_pkg::F_SYN:
            begin
                // Horner step, highest coefficient first
                for (int j = 0; j < bch_pkg::MAX_SYN; j++)
                    syn_reg[j] <= bch_pkg::gf_mul(syn_reg[j], bch_pkg::ALPHA_POW[j+1])
                                  ^ {5'd0, sh_reg[63]};
                sh_reg  <= {sh_reg[62:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
            end
            bch_pkg::F_SCAN:
            begin
                clean_reg <= !syn_any;
                // locator starts at 1, helper at x
                for (int i = 0; i < bch_pkg::MAX_SYN; i++)
                begin
                    c_reg[i]  <= (i == 0) ? 6'd1 : 6'd0;
                    bs_reg[i] <= (i == 1) ? 6'd1 : 6'd0;
                end
                hist_reg  <= '0;
                len_reg   <= 4'd0;
                bprev_reg <= 6'd1;
                cnt_reg   <= 6'd0;
            end
            bch_pkg::F_BM_D:
                d_reg <= d_comb;
            bch_pkg::F_BM_F:
                f_reg <= bch_pkg::gf_mul(d_reg, bch_pkg::GF_INV[bprev_reg]);
            bch_pkg::F_BM_U:
            begin
                if (d_reg != '0)
                begin
                    for (int i = 0; i < bch_pkg::MAX_SYN; i++)
                        c_reg[i] <= c_reg[i] ^ bch_pkg::gf_mul(f_reg, bs_reg[i]);
                end
                if (d_reg != '0 && {len_reg, 1'b0} <= {1'b0, cnt_reg[3:0]})
                begin
                    // length change: old locator becomes the shifted helper
                    bs_reg[0] <= '0;
                    for (int i = 1; i < bch_pkg::MAX_SYN; i++)
                        bs_reg[i] <= coef_mask[i] ? c_reg[i-1] : '0;
                    len_reg   <= cnt_reg[3:0] + 4'd1 - len_reg;
                    bprev_reg <= d_reg;
                end
                else
                begin
                    bs_reg[0] <= '0;
                    for (int i = 1; i < bch_pkg::MAX_SYN; i++)
                        bs_reg[i] <= coef_mask[i] ? bs_reg[i-1] : '0;
                end
                hist_reg[0] <= syn_reg[0];
                for (int i = 1; i < bch_pkg::MAX_SYN; i++)
                    hist_reg[i] <= hist_reg[i-1];
                for (int i = 0; i < bch_pkg::MAX_SYN - 1; i++)
                    syn_reg[i] <= syn_reg[i+1];
                syn_reg[bch_pkg::MAX_SYN-1] <= '0;
                cnt_reg <= cnt_reg + 6'd1;
            end
            bch_pkg::F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/bch_chien.sv @@
//------------------------------------------------------------------------------
// bch_chien
// Chien search over 63 positions, one per cycle, then bit flip and status.
//------------------------------------------------------------------------------
module bch_chien (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  bch_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [63:0]     corrected_word,
    output logic [1:0]      decode_status,
    output logic [2:0]      errors_fixed
);

    bch_pkg::back_state_t state_reg, state_next;

    logic [63:0]      word_reg;
    logic [3:0]       deg_reg;
    logic             search_reg;
    bch_pkg::status_t status_reg;
    bch_pkg::poly_t   g_reg;
    logic [63:0]      flips_reg;
    logic [5:0]       roots_reg;
    logic [5:0]       pos_reg;

    logic             out_valid_reg;
    logic [63:0]      out_word_reg;
    bch_pkg::status_t out_status_reg;
    logic [2:0]       out_fixed_reg;

    logic             is_root;
    logic             out_free;
    logic             load_out;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        is_root = (g_reg[0] ^ g_reg[1] ^ g_reg[2] ^ g_reg[3] ^ g_reg[4] ^ g_reg[5]
                   ^ g_reg[6] ^ g_reg[7] ^ g_reg[8] ^ g_reg[9] ^ g_reg[10]
                   ^ g_reg[11]) == '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bch_pkg::B_IDLE: if (!q_empty)
                                 state_next = q_entry.search ? bch_pkg::B_RUN : bch_pkg::B_DONE;
            bch_pkg::B_RUN:  if (pos_reg == 6'(bch_pkg::NUM_POS - 1))
                                 state_next = bch_pkg::B_DONE;
            bch_pkg::B_DONE: if (out_free) state_next = bch_pkg::B_IDLE;
            default:         state_next = bch_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == bch_pkg::B_IDLE) && !q_empty;
        load_out = (state_reg == bch_pkg::B_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bch_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            word_reg   <= q_entry.word;
            deg_reg    <= q_entry.deg;
            search_reg <= q_entry.search;
            status_reg <= q_entry.status;
            g_reg      <= q_entry.coef;
            flips_reg  <= '0;
            roots_reg  <= 6'd0;
            pos_reg    <= 6'd0;
        end
        if (state_reg == bch_pkg::B_RUN)
        begin
            // position i evaluates C(alpha^-i); term k steps by alpha^-k
            if (is_root)
            begin
                roots_reg <= roots_reg + 6'd1;
                flips_reg[pos_reg + 6'd1] <= 1'b1;
            end
            for (int k = 0; k < bch_pkg::MAX_SYN; k++)
                g_reg[k] <= bch_pkg::gf_mul(g_reg[k],
                            bch_pkg::ALPHA_POW[(bch_pkg::NUM_POS - k) % bch_pkg::NUM_POS]);
            pos_reg <= pos_reg + 6'd1;
        end
        if (load_out)
        begin
            if (search_reg && roots_reg == {2'b0, deg_reg})
            begin
                out_word_reg   <= word_reg ^ flips_reg;
                out_status_reg <= bch_pkg::STAT_FIXED;
                out_fixed_reg  <= deg_reg[2:0];
            end
            else
            begin
                // root count mismatch fails; skipped words keep their status
                out_word_reg   <= word_reg;
                out_status_reg <= search_reg ? bch_pkg::STAT_FAIL : status_reg;
                out_fixed_reg  <= 3'd0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign corrected_word = out_word_reg;
    assign decode_status  = out_status_reg;
    assign errors_fixed   = out_fixed_reg;

endmodule

@@ rtl/bch_checker.sv @@
//------------------------------------------------------------------------------
// bch_checker
// Port-level checks on the decoder result channel.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module bch_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] corrected_word,
    input logic [1:0]  decode_status,
    input logic [2:0]  errors_fixed
);

    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(corrected_word))
    `ASSERT_NEVER(a_status_code, clk, rst_n, out_valid && decode_status == 2'd3)
    `ASSERT_CLK(a_count_zero, clk, rst_n, out_valid && decode_status != bch_pkg::STAT_FIXED |-> errors_fixed == 3'd0)
    `ASSERT_CLK(a_count_range, clk, rst_n, out_valid && decode_status == bch_pkg::STAT_FIXED |-> errors_fixed != 3'd0 && errors_fixed <= 3'd6)

endmodule

bind bch63_decoder_top bch_checker u_bch_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .corrected_word (corrected_word),
    .decode_status  (decode_status),
    .errors_fixed   (errors_fixed)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench: BCH(63) decoder
// Random and directed words with injected bit errors are pushed through the
// decoder under both code modes; every result word is checked against an
// in-bench GF(64) syndrome / Berlekamp-Massey / Chien search predictor.
//------------------------------------------------------------------------------
module testbench;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] codeword;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] corrected_word;
    logic [1:0]  decode_status;
    logic [2:0]  errors_fixed;

    // expected result word
    typedef struct {
        logic [63:0]      word;
        bch_pkg::status_t status;
        logic [2:0]       nfix;
    } decode_res_t;

    logic [63:0]  pending_words[$];
    decode_res_t  expected_results[$];
    logic         mode_shadow;
    int           mismatch_total;
    bit           in_accepted;
    bit           hold_off;
    event         hold_off_go;

    bch63_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .codeword      (codeword),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .corrected_word(corrected_word),
        .decode_status (decode_status),
        .errors_fixed  (errors_fixed)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    //--------------------------------------------------------------------------
    // GF(64) helpers, field polynomial x^6 + x + 1
    //--------------------------------------------------------------------------
    function automatic bch_pkg::gf_t field_mul(bch_pkg::gf_t a, bch_pkg::gf_t b);
        logic [10:0] acc;
        acc = '0;
        for (int i = 0; i < 6; i++)
            if (b[i])
                acc ^= 11'(a) << i;
        for (int i = 10; i >= 6; i--)
            if (acc[i])
                acc ^= 11'h43 << (i - 6);
        return acc[5:0];
    endfunction

    function automatic bch_pkg::gf_t field_pow(bch_pkg::gf_t a, int e);
        bch_pkg::gf_t r;
        r = 6'd1;
        for (int i = 0; i < e; i++)
            r = field_mul(r, a);
        return r;
    endfunction

    // Predict the decoder result for one received word under mode m.
    function automatic decode_res_t decode_bch(logic [63:0] w, logic m);
        decode_res_t  res;
        bch_pkg::gf_t syn[12];
        bch_pkg::gf_t loc[12];
        bch_pkg::gf_t aux[12];
        bch_pkg::gf_t save[12];
        bch_pkg::gf_t shf[12];
        bch_pkg::gf_t a, r, d, scale, x, bprev;
        int    nsyn, tcap, deg, gap, roots;
        bit    any;
        logic [63:0] flips;
        nsyn  = m ? 12 : 6;
        tcap  = nsyn / 2;
        any   = 0;
        flips = '0;
        res.word = w;
        res.status = bch_pkg::STAT_CLEAN;
        res.nfix = 3'd0;
        for (int j = 0; j < nsyn; j++)
        begin
            a = field_pow(6'd2, j + 1);
            r = '0;
            for (int k = 62; k >= 0; k--)
                r = field_mul(r, a) ^ bch_pkg::gf_t'(w[k+1]);
            syn[j] = r;
            if (r != 0)
                any = 1;
        end
        if (!any)
            return res;
        // Berlekamp-Massey
        for (int i = 0; i < 12; i++)
        begin
            loc[i] = (i == 0) ? 6'd1 : 6'd0;
            aux[i] = (i == 0) ? 6'd1 : 6'd0;
        end
        deg = 0;
        gap = 1;
        bprev = 6'd1;
        for (int n = 0; n < nsyn; n++)
        begin
            d = syn[n];
            for (int i = 1; i <= deg && i <= n && i < nsyn; i++)
                d ^= field_mul(loc[i], syn[n-i]);
            if (d == 0)
                gap++;
            else
            begin
                scale = field_mul(d, field_pow(bprev, 62));
                for (int i = 0; i < 12; i++)
                    shf[i] = (i >= gap) ? aux[i-gap] : 6'd0;
                save = loc;
                for (int i = 0; i < nsyn; i++)
                    loc[i] ^= field_mul(scale, shf[i]);
                if (2 * deg <= n)
                begin
                    deg = n + 1 - deg;
                    aux = save;
                    bprev = d;
                    gap = 1;
                end
                else
                    gap++;
            end
        end
        if (deg == 0 || deg > tcap)
        begin
            res.status = bch_pkg::STAT_FAIL;
            return res;
        end
        // Chien search
        roots = 0;
        for (int i = 0; i < 63; i++)
        begin
            x = field_pow(6'd2, (63 - i) % 63);
            r = '0;
            for (int k = nsyn - 1; k >= 0; k--)
                r = field_mul(r, x) ^ loc[k];
            if (r == 0)
            begin
                roots++;
                flips[i+1] = 1'b1;
            end
        end
        if (roots != deg)
        begin
            res.status = bch_pkg::STAT_FAIL;
            return res;
        end
        res.word = w ^ flips;
        res.status = bch_pkg::STAT_FIXED;
        res.nfix = 3'(deg);
        return res;
    endfunction

    // Build a valid codeword: finding a clean word by random search is hopeless,
    // so a random word is corrected by decoding instead; if it decodes
    // without failure the corrected word is a codeword.
    function automatic logic [63:0] make_codeword(logic m);
        decode_res_t res;
        logic [63:0] w;
        for (int tries = 0; tries < 2000; tries++)
        begin
            w = {$urandom, $urandom};
            res = decode_bch(w, m);
            if (res.status != bch_pkg::STAT_FAIL)
                return res.word;
        end
        return {63'd0, w[0]};
    endfunction

    function automatic logic [63:0] add_errors(logic [63:0] w, int nerr);
        int pos;
        for (int i = 0; i < nerr; i++)
        begin
            pos = $urandom_range(63, 1);
            w[pos] = ~w[pos];
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatch_total++;
    endtask

    //--------------------------------------------------------------------------
    // Driver: one word from the pending queue at a time, random gap first.
    //--------------------------------------------------------------------------
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            codeword <= '0;
            send_gap = $urandom_range(19, 0);
        end
        else if (in_valid && !in_accepted)
        begin
            // word still waiting for acceptance
        end
        else
        begin
            if (in_valid)
            begin
                // previous word accepted at last posedge
                send_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(19, 0);
            end
            if (send_gap > 0 || pending_words.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
            else
            begin
                codeword <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // acceptance seen at the rising edge; prediction taken here
    always @(posedge clk)
    begin
        in_accepted <= (rst_n && in_valid && !in_stall);
        if (rst_n && in_valid && !in_stall)
            expected_results.push_back(decode_bch(codeword, mode_shadow));
    end

    //--------------------------------------------------------------------------
    // Monitor and receiver stall
    //--------------------------------------------------------------------------
    always @(posedge clk)
    begin
        decode_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word", corrected_word, '0);
            else
            begin
                want = expected_results.pop_front();
                if (corrected_word !== want.word)
                    report_mismatch("corrected_word", corrected_word, want.word);
                if (decode_status !== want.status)
                    report_mismatch("decode_status", 64'(decode_status), 64'(want.status));
                if (errors_fixed !== want.nfix)
                    report_mismatch("errors_fixed", 64'(errors_fixed), 64'(want.nfix));
            end
        end
    end

    // long receiver hold-off, counted here once the stimulus asks for it
    initial
    begin
        hold_off = 1'b0;
        @(hold_off_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
    end

    int recv_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else if (hold_off)
            out_stall <= 1'b1;
        else if (out_valid && !out_stall)
        begin
            // a new word is offered: draw its stall length
            recv_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(19, 0);
            out_stall <= (recv_gap > 0);
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_stall <= (recv_gap > 0);
        end
        else
            out_stall <= 1'b0;
    end

    //--------------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mode_shadow = m;
    endtask

    task automatic queue_phase(logic m, int count);
        int tcap;
        logic [63:0] cw;
        tcap = m ? 6 : 3;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9, 0))
                0: pending_words.push_back({$urandom, $urandom});
                1: pending_words.push_back(add_errors(make_codeword(m),
                                           $urandom_range(tcap + 4, tcap + 1)));
                default:
                begin
                    cw = make_codeword(m);
                    pending_words.push_back(add_errors(cw, $urandom_range(tcap, 0)));
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        mode_shadow = 1'b0;
        mismatch_total = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset mode (t = 3): extremes and special cases
        pending_words.push_back(64'd0);
        pending_words.push_back(64'd1);                 // only the ignored bit
        pending_words.push_back('1);
        pending_words.push_back(64'h2);                 // single error
        pending_words.push_back(64'h8000_0000_0000_0000);
        pending_words.push_back(64'h0000_0000_0000_002A);
        pending_words.push_back(64'hF000_0000_0000_0F0E); // beyond t
        pending_words.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_words.push_back(64'h5555_5555_5555_5555);
        queue_phase(1'b0, 8);
        wait_drained();

        // t = 6 directed, plus the long receiver hold-off
        write_mode(1'b1);
        pending_words.push_back(64'd0);
        pending_words.push_back('1);
        pending_words.push_back(add_errors(make_codeword(1'b1), 6));
        pending_words.push_back(64'hFFF0_0000_0000_0000);
        queue_phase(1'b1, 10);
        -> hold_off_go;
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_mode(ph[0]);
            queue_phase(ph[0], 145);
            wait_drained();
        end

        if (mismatch_total == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
